// ----- hw/rtl/assert_macros.svh -----
// assertion macros used by the allocator top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication under active-low reset
`define WFPA_ASSERT_IMP(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// a property that must hold on every cycle out of reset
`define WFPA_ASSERT_ALWAYS(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);

`endif

// ----- hw/rtl/wfpa_pkg.sv -----
// package: types and constants of the worst-fit partition allocator
`timescale 1ns / 1ps
`default_nettype none

package wfpa_pkg;

    localparam int MAX_PARTITIONS_DEF = 16;
    localparam int SIZE_BITS_DEF      = 16;

    localparam int CNT_W       = 5;
    localparam int IN_IDX_W    = 4;
    localparam int IN_SIZE_W   = 16;
    localparam int REQ_NUM_W   = 16;

    localparam logic [CNT_W-1:0]     PC_RESET    = 5'd16;
    localparam logic [REQ_NUM_W-1:0] COUNTER_MAX = 16'hFFFF;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DONE
    } wfpa_state_t;

    // control part of the search token passed cell to cell
    typedef struct packed {
        logic valid;
        logic found;
    } tok_ctrl_t;

    // control part of the shared cell write port
    typedef struct packed {
        logic en;
        logic free;
    } cell_wr_t;

endpackage

`default_nettype wire

// ----- hw/rtl/wfpa_cell.sv -----
// one partition cell: holds size and free bit, updates the passing search token
`timescale 1ns / 1ps
`default_nettype none

module wfpa_cell
    import wfpa_pkg::*;
#(
    parameter int IDX       = 0,
    parameter int IDX_W     = 4,
    parameter int AW        = 4,
    parameter int SIZE_BITS = SIZE_BITS_DEF
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic [CNT_W-1:0]     partition_count,
    input  wire cell_wr_t             wr,
    input  wire logic [AW-1:0]        wr_idx,
    input  wire logic [SIZE_BITS-1:0] wr_size,
    input  wire tok_ctrl_t            tok_in,
    input  wire logic [SIZE_BITS-1:0] req_in,
    input  wire logic [IDX_W-1:0]     best_idx_in,
    input  wire logic [SIZE_BITS-1:0] best_size_in,
    output tok_ctrl_t                 tok_out,
    output logic [SIZE_BITS-1:0]      req_out,
    output logic [IDX_W-1:0]          best_idx_out,
    output logic [SIZE_BITS-1:0]      best_size_out
);

    logic                 free_reg;
    logic [SIZE_BITS-1:0] size_reg;
    tok_ctrl_t            tok_reg;
    logic [SIZE_BITS-1:0] req_reg;
    logic [IDX_W-1:0]     best_idx_reg;
    logic [SIZE_BITS-1:0] best_size_reg;

    logic sel;
    logic active;
    logic hit;

    assign sel    = wr.en && (wr_idx == AW'(IDX));
    assign active = IDX < int'(partition_count);

    // strictly larger replaces, so the lower index keeps a tie
    assign hit = tok_in.valid && active && free_reg && (size_reg >= req_in) &&
                 (!tok_in.found || (best_size_in < size_reg));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            free_reg <= 1'b0;
            tok_reg  <= '0;
        end else begin
            if (sel) begin
                free_reg <= wr.free;
            end
            tok_reg.valid <= tok_in.valid;
            tok_reg.found <= tok_in.found || hit;
        end
    end

    always_ff @(posedge aclk) begin
        if (sel) begin
            size_reg <= wr_size;
        end
        req_reg       <= req_in;
        best_idx_reg  <= hit ? IDX_W'(IDX) : best_idx_in;
        best_size_reg <= hit ? size_reg : best_size_in;
    end

    assign tok_out       = tok_reg;
    assign req_out       = req_reg;
    assign best_idx_out  = best_idx_reg;
    assign best_size_out = best_size_reg;

endmodule

`default_nettype wire

// ----- hw/rtl/worst_fit_partition_allocator.sv -----
// top level: worst-fit fixed-partition allocator built as a chain of partition cells
`timescale 1ns / 1ps
`default_nettype none

// A load beat writes one partition size and marks it free; it gives no result. An
// allocate beat sends a search token down the row of MAX_PARTITIONS cells, one
// cell per cycle, each holding one partition. The outcome at the end of the row is
// registered in the pending registers, and the grant is committed into the output
// register once that register is free. One allocate is in flight at a time, so an
// allocate holds s_tready low until its grant is committed. A new beat is taken
// while that result still waits on m_tready, but the commit of the following
// allocate waits until the output register is free, and the input stays stalled
// for as long. partition_count may be written only while the block is idle.

`include "assert_macros.svh"

module worst_fit_partition_allocator
    import wfpa_pkg::*;
#(
    parameter int MAX_PARTITIONS = MAX_PARTITIONS_DEF,
    parameter int SIZE_BITS      = SIZE_BITS_DEF
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             cfg_wr_en,
    input  wire logic [CNT_W-1:0] cfg_wr_data,   // partition_count
    input  wire logic             s_tvalid,
    output logic                  s_tready,
    input  wire logic [23:0]      s_tdata,       // partition_index[3:0], size_value[19:4]
    input  wire logic             s_tuser,       // opcode
    input  wire logic             s_tlast,       // last_request
    output logic                  m_tvalid,
    input  wire logic             m_tready,
    output logic [39:0]           m_tdata,       // chosen_index[3:0], leftover_size[19:4],
                                                 // request_number[35:20]
    output logic                  m_tuser        // granted
);

    localparam int IDX_W = $clog2(MAX_PARTITIONS);
    localparam int AW    = (IDX_W > IN_IDX_W) ? IDX_W : IN_IDX_W;

    wfpa_state_t state_reg, state_next;

    logic [CNT_W-1:0]     count_reg;
    logic [REQ_NUM_W-1:0] req_cnt_reg;
    logic [REQ_NUM_W-1:0] req_cnt_inc;
    logic [REQ_NUM_W-1:0] num_reg;

    logic                 pend_found_reg;
    logic [IDX_W-1:0]     pend_idx_reg;
    logic [SIZE_BITS-1:0] pend_left_reg;

    logic                 m_tvalid_reg;
    logic                 m_granted_reg;
    logic [IN_IDX_W-1:0]  m_index_reg;
    logic [IN_SIZE_W-1:0] m_left_reg;
    logic [REQ_NUM_W-1:0] m_num_reg;

    logic                 accept;
    logic                 out_free;
    logic                 commit;
    logic [SIZE_BITS-1:0] in_size;

    cell_wr_t             wr;
    logic [AW-1:0]        wr_idx;
    logic [SIZE_BITS-1:0] wr_size;

    tok_ctrl_t            tok_ctrl  [MAX_PARTITIONS+1];
    logic [SIZE_BITS-1:0] tok_req   [MAX_PARTITIONS+1];
    logic [IDX_W-1:0]     tok_idx   [MAX_PARTITIONS+1];
    logic [SIZE_BITS-1:0] tok_size  [MAX_PARTITIONS+1];
    logic [MAX_PARTITIONS-1:0] tok_vld_vec;

    assign in_size  = SIZE_BITS'(s_tdata[19:4]);
    assign accept   = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept && s_tuser) begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (tok_ctrl[MAX_PARTITIONS].valid) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        s_tready = 1'b0;
        commit   = 1'b0;
        unique case (state_reg)
            ST_IDLE: s_tready = 1'b1;
            ST_SCAN: s_tready = 1'b0;
            ST_DONE: commit   = out_free;
            default: s_tready = 1'b0;
        endcase
    end

    // one write port into the cells: load from the input or commit of a grant
    always_comb begin
        if (commit) begin
            wr.en   = pend_found_reg;
            wr.free = 1'b0;
            wr_idx  = AW'(pend_idx_reg);
            wr_size = pend_left_reg;
        end else begin
            wr.en   = accept && !s_tuser;
            wr.free = 1'b1;
            wr_idx  = AW'(s_tdata[3:0]);
            wr_size = in_size;
        end
    end

    assign req_cnt_inc = (req_cnt_reg == COUNTER_MAX) ? req_cnt_reg : req_cnt_reg + 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            count_reg    <= PC_RESET;
            req_cnt_reg  <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_wr_en) begin
                count_reg <= cfg_wr_data;
            end
            if (accept && s_tuser) begin
                req_cnt_reg <= s_tlast ? '0 : req_cnt_inc;
            end
            if (commit) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept && s_tuser) begin
            num_reg <= req_cnt_inc;
        end
        if (state_reg == ST_SCAN && tok_ctrl[MAX_PARTITIONS].valid) begin
            pend_found_reg <= tok_ctrl[MAX_PARTITIONS].found;
            pend_idx_reg   <= tok_ctrl[MAX_PARTITIONS].found ? tok_idx[MAX_PARTITIONS] : '0;
            pend_left_reg  <= tok_ctrl[MAX_PARTITIONS].found ?
                              tok_size[MAX_PARTITIONS] - tok_req[MAX_PARTITIONS] : '0;
        end
        if (commit) begin
            m_granted_reg <= pend_found_reg;
            m_index_reg   <= IN_IDX_W'(pend_idx_reg);
            m_left_reg    <= IN_SIZE_W'(pend_left_reg);
            m_num_reg     <= num_reg;
        end
    end

    // token enters the first cell on an accepted allocate beat
    assign tok_ctrl[0].valid = accept && s_tuser;
    assign tok_ctrl[0].found = 1'b0;
    assign tok_req[0]        = in_size;
    assign tok_idx[0]        = '0;
    assign tok_size[0]       = '0;

    for (genvar g = 0; g < MAX_PARTITIONS; g++) begin : g_cell
        wfpa_cell #(
            .IDX       (g),
            .IDX_W     (IDX_W),
            .AW        (AW),
            .SIZE_BITS (SIZE_BITS)
        ) u_cell (
            .aclk            (aclk),
            .aresetn         (aresetn),
            .partition_count (count_reg),
            .wr              (wr),
            .wr_idx          (wr_idx),
            .wr_size         (wr_size),
            .tok_in          (tok_ctrl[g]),
            .req_in          (tok_req[g]),
            .best_idx_in     (tok_idx[g]),
            .best_size_in    (tok_size[g]),
            .tok_out         (tok_ctrl[g+1]),
            .req_out         (tok_req[g+1]),
            .best_idx_out    (tok_idx[g+1]),
            .best_size_out   (tok_size[g+1])
        );
        assign tok_vld_vec[g] = tok_ctrl[g+1].valid;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = m_granted_reg;
    assign m_tdata  = {4'd0, m_num_reg, m_left_reg, m_index_reg};

    `WFPA_ASSERT_ALWAYS(a_one_token, aclk, aresetn, $onehot0(tok_vld_vec),
        "more than one search token in the cell chain")
    `WFPA_ASSERT_IMP(a_token_in_scan, aclk, aresetn, tok_ctrl[MAX_PARTITIONS].valid,
        state_reg == ST_SCAN, "search token left the chain outside a scan")
    `WFPA_ASSERT_IMP(a_denied_zero, aclk, aresetn, m_tvalid && !m_tuser,
        m_tdata[19:0] == 20'd0, "denied result carries nonzero index or leftover")

endmodule

`default_nettype wire

// ----- verif/testbench.sv -----
// testbench for the worst-fit partition allocator: directed and random beats checked against a predictor
`timescale 1ns / 1ps

module testbench;
    import wfpa_pkg::*;

    localparam int   NUM_PART  = 16;
    localparam logic OP_LOAD   = 1'b0;
    localparam logic OP_ALLOC  = 1'b1;
    localparam int   SETTLE    = 40;   // well beyond the search latency
    localparam int   PHASE_LEN = 190;
    localparam int   HOLD_LEN  = 400;
    localparam int   NUM_PHASE = 10;

    typedef struct {
        logic        granted;
        logic [3:0]  index;
        logic [15:0] leftover;
        logic [15:0] number;
    } grant_t;

    class worst_fit_tracker;
        logic [15:0] part_size [NUM_PART];
        bit          part_free [NUM_PART];
        logic [15:0] req_count  = '0;
        int          search_len = NUM_PART;
        grant_t      pending_grants[$];
        int          fail_count = 0;

        function void set_search_len(logic [CNT_W-1:0] v);
            search_len = (v > NUM_PART) ? NUM_PART : int'(v);
        endfunction

        function void note_beat(logic op, logic [3:0] idx, logic [15:0] size, logic last);
            int     best;
            bit     found;
            grant_t g;
            if (op == OP_LOAD) begin
                part_size[idx] = size;
                part_free[idx] = 1'b1;
                return;
            end
            found = 1'b0;
            best  = 0;
            for (int j = 0; j < search_len; j++) begin
                // strict compare keeps the lowest index on a tie
                if (part_free[j] && part_size[j] >= size &&
                    (!found || part_size[j] > part_size[best])) begin
                    best  = j;
                    found = 1'b1;
                end
            end
            if (req_count != COUNTER_MAX)
                req_count++;
            g.number = req_count;
            if (last)
                req_count = '0;
            g.granted  = found;
            g.index    = found ? 4'(best) : 4'd0;
            g.leftover = '0;
            if (found) begin
                g.leftover      = part_size[best] - size;
                part_size[best] = g.leftover;
                part_free[best] = 1'b0;
            end
            pending_grants.push_back(g);
        endfunction

        function void check_grant(logic granted, logic [3:0] idx, logic [15:0] left,
                                  logic [15:0] num);
            grant_t e;
            if (pending_grants.size() == 0) begin
                fail_count++;
                if (fail_count <= 10)
                    $display("%0t: unexpected result beat granted=%b index=%0d", $realtime,
                             granted, idx);
                return;
            end
            e = pending_grants.pop_front();
            if (granted !== e.granted || idx !== e.index || left !== e.leftover ||
                num !== e.number) begin
                fail_count++;
                if (fail_count <= 10)
                    $display("%0t: mismatch exp g=%b i=%0d l=%0d n=%0d got g=%b i=%0d l=%0d n=%0d",
                             $realtime, e.granted, e.index, e.leftover, e.number,
                             granted, idx, left, num);
            end
        endfunction
    endclass

    logic              aclk = 1'b0;
    logic              aresetn;
    logic              cfg_wr_en;
    logic [CNT_W-1:0]  cfg_wr_data;
    logic              s_tvalid;
    logic              s_tready;
    logic [23:0]       s_tdata;
    logic              s_tuser;
    logic              s_tlast;
    logic              m_tvalid;
    logic              m_tready;
    logic [39:0]       m_tdata;
    logic              m_tuser;

    worst_fit_tracker tracker = new;

    int tx_max_gap   = 12;
    int rx_max_stall = 12;
    int hold_request = 0;

    worst_fit_partition_allocator uut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .s_tlast     (s_tlast),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // called at a rising edge; leaves tvalid high so a back-to-back beat needs no toggle
    task automatic send_beat(input logic op, input logic [3:0] idx, input logic [15:0] size,
                             input logic last);
        int gap;
        gap = $urandom_range(0, tx_max_gap);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tlast  <= last;
        s_tdata  <= {4'd0, size, idx};
        @(posedge aclk);
        while (s_tready !== 1'b1) @(posedge aclk);
        tracker.note_beat(op, idx, size, last);
    endtask

    task automatic write_count(input logic [CNT_W-1:0] v);
        while (tracker.pending_grants.size() != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        tracker.set_search_len(v);
    endtask

    function automatic logic [15:0] pick_size();
        case ($urandom_range(0, 7))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            2, 3, 4: return 16'($urandom_range(0, 255));
            default: return 16'($urandom_range(0, 65535));
        endcase
    endfunction

    initial begin : result_sink
        int stall;
        m_tready = 1'b0;
        @(posedge aclk);
        while (aresetn !== 1'b1) @(posedge aclk);
        forever begin
            if (hold_request > 0) begin
                stall        = hold_request;
                hold_request = 0;
            end else begin
                stall = $urandom_range(0, rx_max_stall);
            end
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            @(posedge aclk);
            while (m_tvalid !== 1'b1) @(posedge aclk);
            tracker.check_grant(m_tuser, m_tdata[3:0], m_tdata[19:4], m_tdata[35:20]);
        end
    end

    initial begin : stimulus
        logic [15:0]      dir_sizes [NUM_PART];
        logic [CNT_W-1:0] phase_counts [NUM_PHASE];
        logic             op;
        aresetn     = 1'b0;
        cfg_wr_en   = 1'b0;
        cfg_wr_data = '0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        s_tuser     = OP_LOAD;
        s_tlast     = 1'b0;
        dir_sizes    = '{16'hFFFF, 16'h0000, 16'd40000, 16'd40000, 16'd1, 16'h8000, 16'd255,
                         16'd256, 16'd12345, 16'd7, 16'd30000, 16'hFFFE, 16'd2, 16'd100,
                         16'd1000, 16'd50000};
        phase_counts = '{5'd0, 5'd1, 5'd31, 5'd16, 5'd3, 5'd17, 5'd8, 5'd2, 5'd12, 5'd16};
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // fill the whole table first; the last mark on a load must be ignored
        for (int i = 0; i < NUM_PART; i++)
            send_beat(OP_LOAD, 4'(i), dir_sizes[i], i == NUM_PART - 1);
        send_beat(OP_ALLOC, 4'd0,  16'hFFFF,   1'b0);  // exact fit, zero fragment
        send_beat(OP_ALLOC, 4'd9,  16'h0000,   1'b0);  // zero request takes the largest
        send_beat(OP_ALLOC, 4'd15, 16'd40000,  1'b0);
        send_beat(OP_ALLOC, 4'd0,  16'd40000,  1'b0);  // tie between two equal sizes
        send_beat(OP_ALLOC, 4'd0,  16'd40000,  1'b0);
        send_beat(OP_ALLOC, 4'd0,  16'hFFFF,   1'b0);  // nothing fits
        send_beat(OP_ALLOC, 4'd0,  16'd1,      1'b1);  // ends the batch
        send_beat(OP_LOAD,  4'd0,  16'hFFFF,   1'b1);
        send_beat(OP_ALLOC, 4'd0,  16'hFFFF,   1'b0);
        s_tvalid <= 1'b0;

        for (int p = 0; p < NUM_PHASE; p++) begin
            write_count(phase_counts[p]);
            for (int n = 0; n < PHASE_LEN; n++) begin
                if (n % 40 == 0) begin
                    tx_max_gap   = $urandom_range(0, 1) ? 12 : 0;
                    rx_max_stall = $urandom_range(0, 1) ? 12 : 0;
                end
                // long output stall while beats keep coming, so the input backs up
                if (p == 3 && n == 0) begin
                    tx_max_gap   = 0;
                    hold_request = HOLD_LEN;
                end
                op = ($urandom_range(0, 99) < 35) ? OP_LOAD : OP_ALLOC;
                send_beat(op, 4'($urandom_range(0, 15)), pick_size(), $urandom_range(0, 7) == 0);
            end
            s_tvalid <= 1'b0;
        end

        while (tracker.pending_grants.size() != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
        if (tracker.fail_count == 0 && tracker.pending_grants.size() == 0)
            $display("[worst_fit_partition_allocator] OK");
        else
            $display("[worst_fit_partition_allocator] ERROR");
        $finish;
    end

    initial begin : watchdog
        #10_000_000;
        $display("[worst_fit_partition_allocator] ERROR");
        $finish;
    end

endmodule
